// ===== hdl/ps2s_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2s_pkg
// Shared types and constants for the PS/2 set 2 scan code sequencer.
// ----------------------------------------------------------------------------
package ps2s_pkg;

   // Fixed bytes of the set 2 protocol.
   localparam logic [7:0] BYTE_BREAK  = 8'hF0;
   localparam logic [7:0] BYTE_EXT    = 8'hE0;
   localparam logic [7:0] CODE_LSHIFT = 8'h12;
   localparam logic [7:0] CODE_RSHIFT = 8'h59;

   // Key kinds as carried on req_tuser.
   localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
   localparam logic [2:0] KIND_NORMAL   = 3'd1;
   localparam logic [2:0] KIND_EXTENDED = 3'd2;
   localparam logic [2:0] KIND_NUMLOCK  = 3'd3;
   localparam logic [2:0] KIND_SHIFTCAN = 3'd4;

   localparam int SEQ_MAX = 8;
   localparam int IDX_W   = $clog2(SEQ_MAX);
   localparam int CNT_W   = $clog2(SEQ_MAX + 1);

   // One decoded key event held in the input register.
   typedef struct packed {
      logic [7:0] key_code;
      logic [2:0] key_kind;
      logic       make;
      logic       left_shift_held;
      logic       right_shift_held;
   } event_type;

   // Complete byte sequence of one event; byte 0 goes out first.
   typedef struct packed {
      logic [SEQ_MAX-1:0][7:0] bytes;
      logic [CNT_W-1:0]        count;
   } seq_type;

endpackage

// ===== hdl/ps2s_encoder.sv =====
// ----------------------------------------------------------------------------
// ps2s_encoder
// Builds the full set 2 byte sequence of one key event in a single pass.
// ----------------------------------------------------------------------------
module ps2s_encoder (
   input  ps2s_pkg::event_type evt_i,
   output ps2s_pkg::seq_type   seq_o
);
   import ps2s_pkg::*;

   logic [7:0] c;

   assign c = evt_i.key_code;

   always_comb begin
      seq_o = '0;
      case (evt_i.key_kind)
         KIND_NORMAL: begin
            if (evt_i.make) begin
               seq_o.bytes[0] = c;
               seq_o.count    = CNT_W'(1);
            end else begin
               seq_o.bytes[0] = BYTE_BREAK;
               seq_o.bytes[1] = c;
               seq_o.count    = CNT_W'(2);
            end
         end
         KIND_EXTENDED: begin
            seq_o.bytes[0] = BYTE_EXT;
            if (evt_i.make) begin
               seq_o.bytes[1] = c;
               seq_o.count    = CNT_W'(2);
            end else begin
               seq_o.bytes[1] = BYTE_BREAK;
               seq_o.bytes[2] = c;
               seq_o.count    = CNT_W'(3);
            end
         end
         KIND_NUMLOCK: begin
            seq_o.bytes[0] = BYTE_EXT;
            if (evt_i.make) begin
               seq_o.bytes[1] = CODE_LSHIFT;
               seq_o.bytes[2] = BYTE_EXT;
               seq_o.bytes[3] = c;
               seq_o.count    = CNT_W'(4);
            end else begin
               seq_o.bytes[1] = BYTE_BREAK;
               seq_o.bytes[2] = c;
               seq_o.bytes[3] = BYTE_EXT;
               seq_o.bytes[4] = BYTE_BREAK;
               seq_o.bytes[5] = CODE_LSHIFT;
               seq_o.count    = CNT_W'(6);
            end
         end
         KIND_SHIFTCAN: begin
            seq_o.bytes[0] = BYTE_EXT;
            if (evt_i.make) begin
               // Release the held shifts first, left before right.
               case ({evt_i.left_shift_held, evt_i.right_shift_held})
                  2'b00: begin
                     seq_o.bytes[1] = c;
                     seq_o.count    = CNT_W'(2);
                  end
                  2'b10, 2'b01: begin
                     seq_o.bytes[1] = BYTE_BREAK;
                     seq_o.bytes[2] = evt_i.left_shift_held ? CODE_LSHIFT : CODE_RSHIFT;
                     seq_o.bytes[3] = BYTE_EXT;
                     seq_o.bytes[4] = c;
                     seq_o.count    = CNT_W'(5);
                  end
                  default: begin
                     seq_o.bytes[1] = BYTE_BREAK;
                     seq_o.bytes[2] = CODE_LSHIFT;
                     seq_o.bytes[3] = BYTE_EXT;
                     seq_o.bytes[4] = BYTE_BREAK;
                     seq_o.bytes[5] = CODE_RSHIFT;
                     seq_o.bytes[6] = BYTE_EXT;
                     seq_o.bytes[7] = c;
                     seq_o.count    = CNT_W'(8);
                  end
               endcase
            end else begin
               // Own break, then press the shifts again, right before left.
               seq_o.bytes[1] = BYTE_BREAK;
               seq_o.bytes[2] = c;
               case ({evt_i.left_shift_held, evt_i.right_shift_held})
                  2'b00: begin
                     seq_o.count = CNT_W'(3);
                  end
                  2'b10, 2'b01: begin
                     seq_o.bytes[3] = BYTE_EXT;
                     seq_o.bytes[4] = evt_i.left_shift_held ? CODE_LSHIFT : CODE_RSHIFT;
                     seq_o.count    = CNT_W'(5);
                  end
                  default: begin
                     seq_o.bytes[3] = BYTE_EXT;
                     seq_o.bytes[4] = CODE_RSHIFT;
                     seq_o.bytes[5] = BYTE_EXT;
                     seq_o.bytes[6] = CODE_LSHIFT;
                     seq_o.count    = CNT_W'(7);
                  end
               endcase
            end
         end
         default: begin
            // Unknown kinds and reserved kind values give no bytes.
            seq_o = '0;
         end
      endcase
   end

endmodule

// ===== hdl/ps2s_serializer.sv =====
// ----------------------------------------------------------------------------
// ps2s_serializer
// Holds one built sequence and sends it out one byte per transaction.
// ----------------------------------------------------------------------------
module ps2s_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_i,
   input  ps2s_pkg::seq_type seq_i,
   output logic              free_o,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // code_byte [7:0]
   output logic              rsp_tlast    // last_byte
);
   import ps2s_pkg::*;

   logic [SEQ_MAX-1:0][7:0] bytes_ff, bytes_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        last_idx_ff, last_idx_in;
   logic                    valid_ff, valid_in;
   logic                    done;
   logic [CNT_W-1:0]        last_cnt;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = bytes_ff[idx_ff];
   assign rsp_tlast  = (idx_ff == last_idx_ff);
   assign done       = valid_ff && rsp_tready && rsp_tlast;
   // A new sequence may enter in the same cycle that the old one finishes.
   assign free_o     = !valid_ff || done;
   assign last_cnt   = seq_i.count - CNT_W'(1);

   always_comb begin
      bytes_in    = bytes_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      valid_in    = valid_ff;
      if (load_i) begin
         bytes_in    = seq_i.bytes;
         idx_in      = '0;
         last_idx_in = last_cnt[IDX_W-1:0];
         valid_in    = (seq_i.count != '0);
      end else if (valid_ff && rsp_tready) begin
         if (rsp_tlast) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      bytes_ff    <= bytes_in;
      last_idx_ff <= last_idx_in;
   end

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff <= last_idx_ff)
      else $error("byte index ran past the end of the sequence");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_i |-> (!valid_ff || (rsp_tready && rsp_tlast)))
      else $error("sequence loaded over one still being sent");

   a_keep_going: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("sequence stopped before its last byte");

   a_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> idx_ff == $past(idx_ff) + IDX_W'(1))
      else $error("byte index did not advance after a transaction");
`endif

endmodule

// ===== hdl/ps2_set2_scancode_sequencer.sv =====
// ----------------------------------------------------------------------------
// ps2_set2_scancode_sequencer
// Turns key events into PS/2 scan code set 2 byte sequences.
// ----------------------------------------------------------------------------
// Each key event accepted on the req_ channel yields zero to eight bytes on the
// rsp_ channel, one byte per transaction, with rsp_tlast marking the last byte
// of the event. An accepted event is registered in the input register and is then
// loaded into the serializer register that drives rsp_, once the serializer is
// free. The output sends one byte per cycle while rsp_tready stays high; the
// next event is built in the input register meanwhile and its first byte follows
// the previous last byte without a gap. Events of an unknown kind give no bytes
// and pass through the input register.
module ps2_set2_scancode_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_code [7:0], make [8],
                                    // left_shift_held [9], right_shift_held [10],
                                    // zero [15:11]
   input  logic [2:0]  req_tuser,   // key_kind [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // code_byte [7:0]
   output logic        rsp_tlast    // last_byte
);
   import ps2s_pkg::*;

   event_type evt_ff, evt_in;
   logic      evt_valid_ff, evt_valid_in;
   seq_type   seq;
   logic      ser_free;
   logic      load;

   assign load       = evt_valid_ff && ser_free;
   assign req_tready = !evt_valid_ff || load;

   always_comb begin
      evt_valid_in = evt_valid_ff;
      evt_in       = evt_ff;
      if (req_tvalid && req_tready) begin
         evt_valid_in            = 1'b1;
         evt_in.key_code         = req_tdata[7:0];
         evt_in.make             = req_tdata[8];
         evt_in.left_shift_held  = req_tdata[9];
         evt_in.right_shift_held = req_tdata[10];
         evt_in.key_kind         = req_tuser;
      end else if (load) begin
         evt_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else begin
         evt_valid_ff <= evt_valid_in;
      end
      evt_ff <= evt_in;
   end

   ps2s_encoder u_encoder (
      .evt_i (evt_ff),
      .seq_o (seq)
   );

   ps2s_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_i     (load),
      .seq_i      (seq),
      .free_o     (ser_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/tb_ps2_set2_scancode_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_set2_scancode_sequencer
// Self-checking testbench for the PS/2 set 2 scan code sequencer.
// ----------------------------------------------------------------------------
// Key events are sent on the req_ stream and every scan code byte on the rsp_
// stream is compared with a queue of expected bytes. A directed table covers
// the field extremes, every key kind and the kinds that must stay silent. A
// random run of key events follows under four pacing modes: back to back,
// sender gaps, receiver stalls, and both together.
module tb_ps2_set2_scancode_sequencer;
   import ps2s_pkg::*;

   // Kind values that carry no meaning and must give no bytes.
   localparam logic [2:0] KIND_RSVD5 = 3'd5;
   localparam logic [2:0] KIND_RSVD6 = 3'd6;
   localparam logic [2:0] KIND_RSVD7 = 3'd7;

   // A row with this length takes its bytes from the predictor.
   localparam int PREDICT = -1;
   localparam int N_DIRECTED = 24;
   localparam int EVENTS_PER_PHASE = 50;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_byte;
   } scan_byte_type;

   // Typed sequences read left to right in the order of transmission.
   typedef struct packed {
      logic [7:0]  code;
      logic [2:0]  kind;
      logic        mk;
      logic        lsh;
      logic        rsh;
      int          typed_len;
      logic [63:0] typed_seq;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   scan_byte_type expected_bytes[$];
   int         error_count   = 0;
   int         events_sent   = 0;
   int         silent_events = 0;
   int         bytes_checked = 0;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{8'hFF, KIND_UNKNOWN,  1'b1, 1'b1, 1'b1, 0, 64'h0},
      '{8'h00, KIND_RSVD5,    1'b0, 1'b0, 1'b0, 0, 64'h0},
      '{8'hA5, KIND_RSVD6,    1'b1, 1'b1, 1'b0, 0, 64'h0},
      '{8'h5A, KIND_RSVD7,    1'b0, 1'b0, 1'b1, 0, 64'h0},
      '{8'h00, KIND_NORMAL,   1'b1, 1'b0, 1'b0, 1, 64'h00},
      '{8'hFF, KIND_NORMAL,   1'b1, 1'b1, 1'b1, 1, 64'hFF},
      '{8'h00, KIND_NORMAL,   1'b0, 1'b0, 1'b0, 2, 64'hF000},
      '{8'hFF, KIND_NORMAL,   1'b0, 1'b1, 1'b1, 2, 64'hF0FF},
      '{8'h00, KIND_EXTENDED, 1'b1, 1'b1, 1'b1, 2, 64'hE000},
      '{8'hFF, KIND_EXTENDED, 1'b0, 1'b0, 1'b0, 3, 64'hE0F0FF},
      '{8'h75, KIND_EXTENDED, 1'b1, 1'b0, 1'b1, PREDICT, 64'h0},
      '{8'hFF, KIND_NUMLOCK,  1'b1, 1'b0, 1'b0, 4, 64'hE012E0FF},
      '{8'h00, KIND_NUMLOCK,  1'b0, 1'b0, 1'b0, 6, 64'hE0F000E0F012},
      '{8'h70, KIND_NUMLOCK,  1'b1, 1'b1, 1'b1, PREDICT, 64'h0},
      '{8'h70, KIND_NUMLOCK,  1'b0, 1'b1, 1'b0, PREDICT, 64'h0},
      '{8'h4A, KIND_SHIFTCAN, 1'b1, 1'b1, 1'b1, 8, 64'hE0F012E0F059E04A},
      '{8'h4A, KIND_SHIFTCAN, 1'b0, 1'b1, 1'b1, 7, 64'hE0F04AE059E012},
      '{8'h4A, KIND_SHIFTCAN, 1'b1, 1'b0, 1'b0, PREDICT, 64'h0},
      '{8'h4A, KIND_SHIFTCAN, 1'b0, 1'b0, 1'b0, PREDICT, 64'h0},
      '{8'hFF, KIND_SHIFTCAN, 1'b1, 1'b1, 1'b0, PREDICT, 64'h0},
      '{8'h00, KIND_SHIFTCAN, 1'b0, 1'b0, 1'b1, PREDICT, 64'h0},
      '{8'h4A, KIND_SHIFTCAN, 1'b1, 1'b0, 1'b1, PREDICT, 64'h0},
      '{8'h4A, KIND_SHIFTCAN, 1'b0, 1'b1, 1'b0, PREDICT, 64'h0},
      '{8'h12, KIND_NORMAL,   1'b0, 1'b0, 1'b0, PREDICT, 64'h0}
   };

   ps2_set2_scancode_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Appends the set 2 byte sequence of one key event to the expected queue.
   function automatic int predict_scan_sequence(input event_type ev);
      logic [7:0] seq[$];
      int         k;
      case (ev.key_kind)
         KIND_NORMAL: begin
            if (!ev.make) seq.push_back(BYTE_BREAK);
            seq.push_back(ev.key_code);
         end
         KIND_EXTENDED: begin
            seq.push_back(BYTE_EXT);
            if (!ev.make) seq.push_back(BYTE_BREAK);
            seq.push_back(ev.key_code);
         end
         KIND_NUMLOCK: begin
            if (ev.make) begin
               seq = '{BYTE_EXT, CODE_LSHIFT, BYTE_EXT, ev.key_code};
            end else begin
               seq = '{BYTE_EXT, BYTE_BREAK, ev.key_code, BYTE_EXT, BYTE_BREAK, CODE_LSHIFT};
            end
         end
         KIND_SHIFTCAN: begin
            if (ev.make) begin
               if (ev.left_shift_held) seq = {seq, BYTE_EXT, BYTE_BREAK, CODE_LSHIFT};
               if (ev.right_shift_held) seq = {seq, BYTE_EXT, BYTE_BREAK, CODE_RSHIFT};
               seq = {seq, BYTE_EXT, ev.key_code};
            end else begin
               seq = {seq, BYTE_EXT, BYTE_BREAK, ev.key_code};
               if (ev.right_shift_held) seq = {seq, BYTE_EXT, CODE_RSHIFT};
               if (ev.left_shift_held) seq = {seq, BYTE_EXT, CODE_LSHIFT};
            end
         end
         default: ;
      endcase
      for (k = 0; k < seq.size(); k++) begin
         expected_bytes.push_back('{seq[k], k == seq.size() - 1});
      end
      return seq.size();
   endfunction

   // Drives one key event and records its expected bytes once it is accepted.
   task automatic send_key_event(input event_type ev, input int typed_len,
                                 input logic [63:0] typed_seq);
      int n;
      int k;
      @(negedge clock);
      while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {5'b0, ev.right_shift_held, ev.left_shift_held, ev.make, ev.key_code};
      req_tuser  = ev.key_kind;
      do @(posedge clock); while (!req_tready);
      if (typed_len == PREDICT) begin
         n = predict_scan_sequence(ev);
      end else begin
         n = typed_len;
         for (k = 0; k < typed_len; k++) begin
            expected_bytes.push_back('{typed_seq[8*(typed_len-1-k) +: 8],
                                       k == typed_len - 1});
         end
      end
      events_sent++;
      if (n == 0) silent_events++;
   endtask

   // Lowers valid and holds off until every expected byte has arrived.
   task automatic drain_outstanding();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
   endtask

   // Receiver pacing: ready is redrawn at every falling edge.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = (receiver_stall_pct == 0) ||
                      ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      scan_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            $error("unexpected code_byte: actual %02h last_byte %0b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.code_byte) begin
               $error("code_byte mismatch: expected %02h actual %02h",
                      want.code_byte, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last_byte) begin
               $error("last_byte mismatch: expected %0b actual %0b",
                      want.last_byte, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      event_type ev;
      int        phase;
      int        real_events;
      int        i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_UNKNOWN;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         ev.key_code         = directed_rows[i].code;
         ev.key_kind         = directed_rows[i].kind;
         ev.make             = directed_rows[i].mk;
         ev.left_shift_held  = directed_rows[i].lsh;
         ev.right_shift_held = directed_rows[i].rsh;
         send_key_event(ev, directed_rows[i].typed_len, directed_rows[i].typed_seq);
      end
      drain_outstanding();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
            default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
         endcase
         real_events = 0;
         while (real_events < EVENTS_PER_PHASE) begin
            ev.key_code         = 8'($urandom_range(0, 255));
            ev.make             = 1'($urandom_range(0, 1));
            ev.left_shift_held  = 1'($urandom_range(0, 1));
            ev.right_shift_held = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 88) begin
               ev.key_kind = 3'($urandom_range(KIND_NORMAL, KIND_SHIFTCAN));
               real_events++;
            end else if ($urandom_range(0, 1) == 0) begin
               ev.key_kind = KIND_UNKNOWN;
            end else begin
               ev.key_kind = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
            end
            send_key_event(ev, PREDICT, 64'h0);
         end
         // The sender waits here until the block has delivered everything.
         drain_outstanding();
      end

      repeat (16) @(posedge clock);
      $display("Sent %0d key events (%0d silent) and checked %0d scan code bytes.",
               events_sent, silent_events, bytes_checked);
      $display("Pacing ran back to back, with sender gaps, receiver stalls and both.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d bytes still expected.", expected_bytes.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
